// File: hw/rtl/ifmt_pkg.sv
package ifmt_pkg;

  // Conversion kinds carried on the conversion field
  typedef enum logic [2:0] {
    CONV_SDEC = 3'd0,
    CONV_UDEC = 3'd1,
    CONV_LHEX = 3'd2,
    CONV_UHEX = 3'd3,
    CONV_PTR  = 3'd4
  } conv_e;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CONV  = 9'b000000010,
    ST_SETUP = 9'b000000100,
    ST_SPACE = 9'b000001000,
    ST_SIGN  = 9'b000010000,
    ST_PRE0  = 9'b000100000,
    ST_PREX  = 9'b001000000,
    ST_ZERO  = 9'b010000000,
    ST_DIGIT = 9'b100000000
  } state_e;

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned CNT_W      = 6;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  localparam logic [3:0] HEX_DIGITS = 4'd8;

endpackage

// File: hw/rtl/integer_field_formatter.sv
// Integer field formatter: turns one 32-bit word into a formatted ASCII field.
// Input: raise start_i with conversion_i, value_i, width_i, precision_i,
// zero_pad_i, alternate_i and left_align_i; the item is taken at the clock
// edge where start_i is high and busy_o is low. busy_o stays high until the
// last character of the field has left.
// Output: one character per cycle on character_o, marked by char_valid_o;
// last_o flags the final character. The receiver cannot stall, so characters
// leave back to back without gaps once emission starts.
// Decimal kinds run a shift-and-add-3 binary to BCD loop, one bit a cycle;
// hex and pointer load their nibbles directly. A setup state then sizes
// padding, and characters follow one per cycle.
// A field is 1 to 62 characters long. A new item is taken only once busy_o
// has fallen; the BCD loop dominates the busy time of the decimal kinds.
// Unused conversion codes are taken and produce no characters.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// any field in progress.
module integer_field_formatter
  import ifmt_pkg::*;
#(
  parameter int unsigned MAX_PAD = 60
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [2:0]              conversion_i,
  input  logic [VAL_W-1:0]        value_i,
  input  logic [CNT_W-1:0]        width_i,
  input  logic [CNT_W-1:0]        precision_i,
  input  logic                    zero_pad_i,
  input  logic                    alternate_i,
  input  logic                    left_align_i,
  output logic                    char_valid_o,
  output logic [7:0]              character_o,
  output logic                    last_o
);

  localparam logic [CNT_W-1:0] MaxPad   = CNT_W'(MAX_PAD);
  localparam logic [4:0]       ConvLast = 5'(VAL_W - 1);

  // Pick the first non-empty emission phase in field order
  function automatic state_e pick_phase(input logic sp, input logic sg,
                                        input logic pf, input logic zr);
    state_e s;
    if (sp) begin
      s = ST_SPACE;
    end else if (sg) begin
      s = ST_SIGN;
    end else if (pf) begin
      s = ST_PRE0;
    end else if (zr) begin
      s = ST_ZERO;
    end else begin
      s = ST_DIGIT;
    end
    return s;
  endfunction

  // Significant digit count, at least one
  function automatic logic [3:0] digit_count(input logic [BCD_W-1:0] d);
    logic [3:0] n;
    int         i;
    n = 4'd1;
    for (i = 0; i < BCD_DIGITS; i++) begin
      if (d[4*i +: 4] != 4'd0) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

  state_e             state_q, state_d;
  conv_e              conv_q, conv_d;
  logic               neg_q, neg_d;
  logic               prefix_q, prefix_d;
  logic               zp_q, zp_d;
  logic [CNT_W-1:0]   w_q, w_d;
  logic [CNT_W-1:0]   p_q, p_d;
  logic [VAL_W-1:0]   bin_q, bin_d;
  logic [BCD_W-1:0]   dig_q, dig_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]   spaces_q, spaces_d;
  logic [CNT_W-1:0]   zeros_q, zeros_d;
  logic [3:0]         idx_q, idx_d;

  logic               accept;
  logic [BCD_W-1:0]   dig_adj;
  logic [3:0]         nd;
  logic signed [7:0]  len_s, w_s, p_s, max_lp, target_s, sp_s, zr_s;
  logic [CNT_W-1:0]   sp_cnt, zr_cnt;
  logic [3:0]         nib;
  logic [7:0]         letter;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // Add-3 correction on every BCD digit: the shared step of the BCD loop
  always_comb begin
    for (int j = 0; j < BCD_DIGITS; j++) begin
      dig_adj[4*j +: 4] = (dig_q[4*j +: 4] >= 4'd5) ? dig_q[4*j +: 4] + 4'd3
                                                     : dig_q[4*j +: 4];
    end
  end

  // Field sizing, used in the setup cycle
  always_comb begin
    nd       = digit_count(dig_q);
    len_s    = $signed({4'b0000, nd}) + $signed({7'b0000000, neg_q});
    w_s      = $signed({2'b00, w_q}) - (prefix_q ? 8'sd2 : 8'sd0);
    p_s      = $signed({2'b00, p_q});
    max_lp   = (len_s > p_s) ? len_s : p_s;
    target_s = (zp_q && (p_q == '0)) ? w_s : p_s;
    sp_s     = zp_q ? 8'sd0 : (w_s - max_lp);
    zr_s     = target_s - len_s;
    sp_cnt   = sp_s[7] ? '0 : sp_s[CNT_W-1:0];
    zr_cnt   = zr_s[7] ? '0 : zr_s[CNT_W-1:0];
    if (conv_q == CONV_UDEC) begin
      sp_cnt = '0;
      zr_cnt = '0;
    end else if (conv_q == CONV_PTR) begin
      sp_cnt = '0;
      zr_cnt = {2'b00, HEX_DIGITS - nd};
    end
  end

  always_comb begin
    state_d  = state_q;
    conv_d   = conv_q;
    neg_d    = neg_q;
    prefix_d = prefix_q;
    zp_d     = zp_q;
    w_d      = w_q;
    p_d      = p_q;
    bin_d    = bin_q;
    dig_d    = dig_q;
    cnt_d    = cnt_q;
    spaces_d = spaces_q;
    zeros_d  = zeros_q;
    idx_d    = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          conv_d   = conv_e'(conversion_i);
          zp_d     = zero_pad_i;
          w_d      = (width_i > MaxPad) ? MaxPad : width_i;
          p_d      = (precision_i > MaxPad) ? MaxPad : precision_i;
          neg_d    = 1'b0;
          prefix_d = 1'b0;
          cnt_d    = '0;
          case (conv_e'(conversion_i))
            CONV_SDEC: begin
              neg_d   = value_i[VAL_W-1];
              bin_d   = value_i[VAL_W-1] ? (~value_i + VAL_W'(1)) : value_i;
              dig_d   = '0;
              state_d = ST_CONV;
            end
            CONV_UDEC: begin
              bin_d   = value_i;
              dig_d   = '0;
              state_d = ST_CONV;
            end
            CONV_LHEX, CONV_UHEX: begin
              prefix_d = alternate_i && !left_align_i;
              dig_d    = {{(BCD_W-VAL_W){1'b0}}, value_i};
              state_d  = ST_SETUP;
            end
            CONV_PTR: begin
              prefix_d = 1'b1;
              dig_d    = {{(BCD_W-VAL_W){1'b0}}, value_i};
              state_d  = ST_SETUP;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_CONV: begin
        // shift one binary bit into the corrected BCD word
        dig_d = {dig_adj[BCD_W-2:0], bin_q[VAL_W-1]};
        bin_d = {bin_q[VAL_W-2:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == ConvLast) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        spaces_d = sp_cnt;
        zeros_d  = zr_cnt;
        idx_d    = nd - 4'd1;
        state_d  = pick_phase(sp_cnt != '0, neg_q, prefix_q, zr_cnt != '0);
      end
      ST_SPACE: begin
        spaces_d = spaces_q - CNT_W'(1);
        if (spaces_q == CNT_W'(1)) begin
          state_d = pick_phase(1'b0, neg_q, prefix_q, zeros_q != '0);
        end
      end
      ST_SIGN: begin
        state_d = pick_phase(1'b0, 1'b0, prefix_q, zeros_q != '0);
      end
      ST_PRE0: begin
        state_d = ST_PREX;
      end
      ST_PREX: begin
        state_d = pick_phase(1'b0, 1'b0, 1'b0, zeros_q != '0);
      end
      ST_ZERO: begin
        zeros_d = zeros_q - CNT_W'(1);
        if (zeros_q == CNT_W'(1)) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        idx_d = idx_q - 4'd1;
        if (idx_q == 4'd0) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Character decode from the current phase
  always_comb begin
    nib          = dig_q[{idx_q, 2'b00} +: 4];
    letter       = (conv_q == CONV_LHEX) ? CH_LOW_A : CH_UP_A;
    char_valid_o = 1'b1;
    last_o       = 1'b0;
    case (state_q)
      ST_SPACE: character_o = CH_SPACE;
      ST_SIGN:  character_o = CH_MINUS;
      ST_PRE0:  character_o = CH_ZERO;
      ST_PREX:  character_o = (conv_q == CONV_UHEX) ? CH_UP_X : CH_LOW_X;
      ST_ZERO:  character_o = CH_ZERO;
      ST_DIGIT: begin
        character_o = (nib < 4'd10) ? (CH_ZERO + {4'b0000, nib})
                                    : (letter + {4'b0000, nib} - 8'd10);
        last_o      = (idx_q == 4'd0);
      end
      default: begin
        character_o  = 8'h00;
        char_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers hold their value unless the sequencer advances them
  always_ff @(posedge clk_i) begin
    conv_q   <= conv_d;
    neg_q    <= neg_d;
    prefix_q <= prefix_d;
    zp_q     <= zp_d;
    w_q      <= w_d;
    p_q      <= p_d;
    bin_q    <= bin_d;
    dig_q    <= dig_d;
    cnt_q    <= cnt_d;
    spaces_q <= spaces_d;
    zeros_q  <= zeros_d;
    idx_q    <= idx_d;
  end

  // A character only leaves while a field is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> busy_o)
    else $error("character strobe while idle");

  // The final character frees the block for the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> !busy_o)
    else $error("still busy after last character");

  // A meaningful conversion always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (conversion_i == CONV_SDEC || conversion_i == CONV_UDEC ||
     conversion_i == CONV_LHEX || conversion_i == CONV_UHEX ||
     conversion_i == CONV_PTR)) |=> busy_o)
    else $error("accepted item did not start");

  // Strobes only in emission phases, never during the BCD loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> !char_valid_o)
    else $error("character during conversion");

endmodule
